// ===== design/tksi_pkg.sv =====
`timescale 1ns / 1ps

package tksi_pkg;

  // table geometry
  localparam int TABLE_SIZE = 10;
  localparam int NAME_W     = 64;
  localparam int TIME_W     = 24;
  localparam int RESULT_W   = 4;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

  // one stored entry, also the form of an incoming item
  typedef struct packed {
    logic [NAME_W-1:0] player_name;
    logic [TIME_W-1:0] total_time;
  } entry_t;

  // one result item
  typedef struct packed {
    logic [RESULT_W-1:0] rank_position;
    logic                name_was_new;
    logic [RESULT_W-1:0] entry_count;
  } result_t;

endpackage

// ===== design/top_k_sorted_insert_top.sv =====
`timescale 1ns / 1ps

// Leaderboard of the TABLE_SIZE best (name, time) entries, kept in ascending
// time order; a new entry goes after stored entries of equal time, and the
// entry that falls off the end of a full table (possibly the new one) is
// lost. Each accepted item gives one result: rank of the first stored entry
// equal in name and time, else of the new entry (0 if it was dropped),
// whether the name was absent before, and the entry count. An item occupies
// the block until its scan is done and its result is taken: the table sits
// in one single-port-read memory and every stored entry is read once, one
// per cycle, and written back shifted when it lies past the insertion slot.
// A new item is taken while the previous result still waits in the output
// register.
module top_k_sorted_insert_top import tksi_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NAME_W-1:0]   player_name,
  input  logic [TIME_W-1:0]   total_time,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RESULT_W-1:0] rank_position,
  output logic                name_was_new,
  output logic [RESULT_W-1:0] entry_count
);

  entry_t  key_in;
  logic    eng_idle;
  logic    res_ready;
  logic    res_valid;
  result_t res;
  result_t out_q;

  assign key_in.player_name = player_name;
  assign key_in.total_time  = total_time;

  // input transfer whenever the scan engine is free
  assign in_ready = eng_idle;

  // engine may finish when the output register is empty or draining
  assign res_ready = !out_valid || out_ready;

  tksi_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .key_in    (key_in),
    .idle      (eng_idle),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rank_position = out_q.rank_position;
  assign name_was_new  = out_q.name_was_new;
  assign entry_count   = out_q.entry_count;

endmodule

// ===== design/tksi_scan.sv =====
`timescale 1ns / 1ps

module tksi_scan import tksi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  entry_t  key_in,
  output logic    idle,
  input  logic    res_ready,
  output logic    res_valid,
  output result_t res
);

  localparam logic       ST_IDLE    = 1'b0;
  localparam logic       ST_SCAN    = 1'b1;
  localparam [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_SIZE);

  // entry storage, one read and one write port, registered read
  entry_t            mem [TABLE_SIZE];
  entry_t            rd_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  logic              state;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  rd_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  proc_idx;
  logic              slot_found;
  logic [IDX_W-1:0]  slot;
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;
  logic              fresh;
  entry_t            key;
  entry_t            carry;

  logic              name_hit;
  logic              time_gt;
  logic              shifting;
  logic              exact;
  logic              scan_end;
  logic              commit;
  logic              has_room;
  logic              inserted;
  logic [IDX_W-1:0]  slot_eff;
  logic [CNT_W-1:0]  rank_full;
  logic [CNT_W-1:0]  cnt_after;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // compare of the entry that just came out of memory
  assign name_hit = (rd_data.player_name == key.player_name);
  assign time_gt  = (rd_data.total_time > key.total_time);
  assign exact    = name_hit && (rd_data.total_time == key.total_time);
  assign shifting = slot_found || time_gt;

  // scan control
  assign idle     = (state == ST_IDLE);
  assign rd_en    = (state == ST_SCAN) && (rd_idx < cnt);
  assign rd_addr  = rd_idx[IDX_W-1:0];
  assign scan_end = (state == ST_SCAN) && (rd_idx == cnt) && !rd_pend;
  assign commit   = scan_end && res_ready;
  assign has_room = (cnt < FULL_COUNT);
  assign inserted = has_room || slot_found;
  assign slot_eff = slot_found ? slot : cnt[IDX_W-1:0];

  // write back: shift from the insertion slot on, then append at the tail
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx;
    wr_data = carry;
    if (rd_pend && shifting) begin
      wr_en = 1'b1;
    end else if (commit && has_room) begin
      wr_en   = 1'b1;
      wr_addr = cnt[IDX_W-1:0];
    end
  end

  // result assembly
  always_comb begin
    if (match_found) begin
      rank_full = CNT_W'(match_idx) + CNT_W'(1);
    end else if (inserted) begin
      rank_full = CNT_W'(slot_eff) + CNT_W'(1);
    end else begin
      rank_full = '0;
    end
    cnt_after = has_room ? cnt + CNT_W'(1) : cnt;
  end

  assign res_valid         = commit;
  assign res.rank_position = RESULT_W'(rank_full);
  assign res.name_was_new  = fresh;
  assign res.entry_count   = RESULT_W'(cnt_after);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      slot_found  <= 1'b0;
      match_found <= 1'b0;
      fresh       <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state       <= ST_SCAN;
            rd_idx      <= '0;
            rd_pend     <= 1'b0;
            slot_found  <= 1'b0;
            match_found <= 1'b0;
            fresh       <= 1'b1;
          end
        end
        ST_SCAN: begin
          rd_pend <= rd_en;
          if (rd_en) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (rd_pend) begin
            if (name_hit) begin
              fresh <= 1'b0;
            end
            if (!slot_found && time_gt) begin
              slot_found <= 1'b1;
            end
            if (!shifting && exact) begin
              match_found <= 1'b1;
            end
          end
          if (commit) begin
            state <= ST_IDLE;
            cnt   <= cnt_after;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start && idle) begin
      key   <= key_in;
      carry <= key_in;
    end
    if (rd_en) begin
      proc_idx <= rd_addr;
    end
    if (rd_pend) begin
      if (shifting) begin
        carry <= rd_data;
      end
      if (!slot_found && time_gt) begin
        slot <= proc_idx;
      end
      if (!shifting && exact && !match_found) begin
        match_idx <= proc_idx;
      end
    end
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FULL_COUNT)
    else $error("valid count above table size");

  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (CNT_W'(proc_idx) < cnt))
    else $error("read of an entry beyond the valid count");

  a_write_scan: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == ST_SCAN))
    else $error("table write outside a scan");

  a_res_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (cnt_after != '0) && (rank_full <= cnt_after))
    else $error("result rank beyond count or empty table after insert");

endmodule
